[sv/sts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

  // One incoming vertex: position in Q3.12, texture coordinate in Q1.15.
  typedef struct packed {
    logic [15:0] v;
    logic [15:0] u;
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
  } vertex_t;

  // A whole input triangle, vertices in arrival order.
  typedef struct packed {
    vertex_t c;
    vertex_t b;
    vertex_t a;
  } tri_t;

  // Point index inside the back end: a, b, c, then the midpoints d, e, f.
  typedef logic [2:0] pidx_t;

  localparam pidx_t PT_A = 3'd0;
  localparam pidx_t PT_B = 3'd1;
  localparam pidx_t PT_C = 3'd2;
  localparam pidx_t PT_D = 3'd3;
  localparam pidx_t PT_E = 3'd4;
  localparam pidx_t PT_F = 3'd5;

  // End points of each midpoint d, e, f (the fourth entry is never used).
  localparam pidx_t MID_A [4] = '{PT_A, PT_B, PT_A, PT_A};
  localparam pidx_t MID_B [4] = '{PT_B, PT_C, PT_C, PT_A};

  // The four output triangles: (a,d,f), (d,e,f), (f,e,c), (d,b,e).
  localparam pidx_t TRI_PT [4][3] = '{
    '{PT_A, PT_D, PT_F},
    '{PT_D, PT_E, PT_F},
    '{PT_F, PT_E, PT_C},
    '{PT_D, PT_B, PT_E}
  };

  localparam int unsigned SQRT_STEPS = 31;
  localparam int unsigned DIV_STEPS  = 45;

endpackage

`default_nettype wire

[sv/sphere_triangle_subdivider.sv]
`timescale 1ns / 1ps
`default_nettype none

// Icosphere midpoint subdivision, one level per pass.
// Vertices enter on the s_axis channel, one per beat; every third beat
// closes a triangle. For each triangle twelve vertex beats leave on m_axis:
// triangles (a,d,f), (d,e,f), (f,e,c), (d,b,e), each vertex carrying its
// flat face normal, with tlast on the twelfth beat.
// The sphere radius (Q3.12) is written through cfg_we_i / cfg_wdata_i; the
// user must write it only while the block is idle, as the block itself does
// not enforce this. Reset sets it to 1.0. The first two vertices of a
// triangle are always taken; the third is taken as soon as the two-entry
// triangle queue has room. In the back end each triangle passes through
// three midpoints and four normals, each through a bit-pair square root
// and three bit-serial divisions, with shifting to normalise each normal,
// then twelve output beats; it takes a new triangle only when it is idle
// again, after its last output beat has been loaded.
// Reset empties the queue and the output register and forgets any partly
// received triangle. When the receiver stalls, the output register holds its
// beat, the back end waits and the front keeps filling the queue.
module sphere_triangle_subdivider import sts_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [14:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v
  input  wire logic [79:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_x, out_y, out_z, norm_x, norm_y, norm_z, out_u, out_v
  output logic [127:0]      m_axis_tdata,
  output logic              m_axis_tlast
);

  logic [14:0] radius_q;
  logic        push_valid;
  logic        push_ready;
  tri_t        push_tri;
  logic        pop_valid;
  logic        pop_ready;
  tri_t        pop_tri;
  vertex_t     in_vtx;

  assign in_vtx = vertex_t'(s_axis_tdata);

  // Radius register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 15'd4096;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  sts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_vtx_i     (in_vtx),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_tri_o   (push_tri)
  );

  sts_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_tri_i   (push_tri),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_tri_o    (pop_tri)
  );

  sts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radius_i    (radius_q),
    .tri_valid_i (pop_valid),
    .tri_ready_o (pop_ready),
    .tri_i       (pop_tri),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

[sv/sts_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module sts_front import sts_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire vertex_t in_vtx_i,
  output logic         push_valid_o,
  input  wire logic    push_ready_i,
  output tri_t         push_tri_o
);

  logic [1:0] cnt_q;
  vertex_t    hold_q [2];
  logic       accept;

  // The first two vertices are always taken; the third waits for queue space.
  assign in_ready_o   = (cnt_q != 2'd2) || push_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = in_valid_i && (cnt_q == 2'd2);
  assign push_tri_o   = '{c: in_vtx_i, b: hold_q[1], a: hold_q[0]};

  // Vertex counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (accept) begin
      cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
    end
  end

  // Held vertices.
  always_ff @(posedge clk_i) begin
    if (accept && (cnt_q != 2'd2)) begin
      hold_q[cnt_q[0]] <= in_vtx_i;
    end
  end

endmodule

`default_nettype wire

[sv/sts_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module sts_queue import sts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire tri_t push_tri_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output tri_t      pop_tri_o
);

  tri_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] fill_q;
  logic       push;
  logic       pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_tri_o    = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_tri_i;
    end
  end

endmodule

`default_nettype wire

[sv/sts_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module sts_back import sts_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [14:0] radius_i,
  input  wire logic        tri_valid_i,
  output logic             tri_ready_o,
  input  wire tri_t        tri_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [127:0]     out_data_o,
  output logic             out_last_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_M_LD, ST_M_SQ, ST_M_MUL, ST_M_DLD, ST_SQRT, ST_DIV,
    ST_N_LD, ST_N_CR, ST_N_MAG, ST_N_NORM, ST_N_SQ, ST_N_DLD, ST_EMIT
  } state_e;

  state_e     state_q;
  logic [1:0] j_q;
  logic [2:0] k_q;
  logic [5:0] cnt_q;
  logic       nmode_q;
  logic       out_valid_q;
  logic       out_last_q;

  logic [2:0][15:0]   pt_q  [6];
  logic [1:0][15:0]   tx_q  [3];
  logic [2:0][15:0]   nrm_q [4];
  logic [2:0][15:0]   vp_q  [3];
  logic signed [16:0] sum_q [3];
  logic signed [35:0] crs_q [3];
  logic [35:0]        mag_q [3];
  logic [61:0]        acc_q;
  logic signed [61:0] prod_q;
  logic [61:0]        rad_q;
  logic [32:0]        srem_q;
  logic [30:0]        root_q;
  logic [30:0]        len_q;
  logic [44:0]        num_q;
  logic [30:0]        drem_q;
  logic [44:0]        quo_q;
  logic [2:0][15:0]   opos_q;
  logic [2:0][15:0]   onrm_q;
  logic [1:0][15:0]   otex_q;

  pidx_t              rd_idx;
  logic [2:0][15:0]   rd_pt;
  logic [1:0][15:0]   rd_tex;
  logic [1:0]         kk;
  logic signed [30:0] mul_a;
  logic signed [30:0] mul_b;
  logic [61:0]        acc_nx;
  logic signed [16:0] u_s [3];
  logic signed [16:0] w_s [3];
  logic [16:0]        abs_s;
  logic [35:0]        or_m;
  logic [34:0]        sq_cur;
  logic [34:0]        sq_trial;
  logic               sq_ge;
  logic [34:0]        sq_diff;
  logic [31:0]        dv_cur;
  logic               dv_ge;
  logic [31:0]        dv_diff;
  logic [44:0]        quo_nx;
  logic [15:0]        mid_res;
  logic [15:0]        nrm_res;
  logic [2:0]         km1;
  logic               out_free;
  logic               out_load;
  logic               emit_last;
  logic               sqrt_done;
  logic               div_done;

  assign kk          = k_q[1:0];
  assign tri_ready_o = (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_load    = (state_q == ST_EMIT) && out_free;
  assign emit_last   = (j_q == 2'd3) && (k_q == 3'd2);
  assign sqrt_done   = (cnt_q == 6'(SQRT_STEPS - 1));
  assign div_done    = (cnt_q == 6'(DIV_STEPS - 1));
  assign km1         = k_q - 3'd1;

  // Average of two texture values, rounding halves up.
  function automatic logic [15:0] tavg(logic [15:0] p, logic [15:0] q);
    logic [16:0] s;
    s = {1'b0, p} + {1'b0, q} + 17'd1;
    return s[16:1];
  endfunction

  // Single read port into the point store.
  always_comb begin
    unique case (state_q)
      ST_M_LD: rd_idx = (k_q == 3'd0) ? MID_A[j_q] : MID_B[j_q];
      ST_N_LD, ST_EMIT: rd_idx = TRI_PT[j_q][kk];
      default: rd_idx = PT_A;
    endcase
  end
  assign rd_pt = pt_q[rd_idx];

  // Texture of the point being emitted; midpoints are averaged on the fly.
  always_comb begin
    unique case (rd_idx)
      PT_A: rd_tex = tx_q[0];
      PT_B: rd_tex = tx_q[1];
      PT_C: rd_tex = tx_q[2];
      PT_D: rd_tex = {tavg(tx_q[0][1], tx_q[1][1]), tavg(tx_q[0][0], tx_q[1][0])};
      PT_E: rd_tex = {tavg(tx_q[1][1], tx_q[2][1]), tavg(tx_q[1][0], tx_q[2][0])};
      PT_F: rd_tex = {tavg(tx_q[0][1], tx_q[2][1]), tavg(tx_q[0][0], tx_q[2][0])};
      default: rd_tex = tx_q[0];
    endcase
  end

  // Edge vectors of the current triangle.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_s[i] = $signed({vp_q[0][i][15], vp_q[0][i]}) - $signed({vp_q[1][i][15], vp_q[1][i]});
      w_s[i] = $signed({vp_q[0][i][15], vp_q[0][i]}) - $signed({vp_q[2][i][15], vp_q[2][i]});
    end
  end

  assign abs_s = sum_q[kk][16] ? 17'(-sum_q[kk]) : 17'(sum_q[kk]);
  assign or_m  = mag_q[0] | mag_q[1] | mag_q[2];

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_M_SQ: begin
        if (k_q < 3'd3) begin
          mul_a = 31'(sum_q[kk]);
          mul_b = 31'(sum_q[kk]);
        end
      end
      ST_M_MUL: begin
        mul_a = $signed({14'd0, abs_s});
        mul_b = $signed({16'd0, radius_i});
      end
      ST_N_CR: begin
        unique case (k_q)
          3'd0: begin mul_a = 31'(u_s[1]); mul_b = 31'(w_s[2]); end
          3'd1: begin mul_a = 31'(u_s[2]); mul_b = 31'(w_s[1]); end
          3'd2: begin mul_a = 31'(u_s[2]); mul_b = 31'(w_s[0]); end
          3'd3: begin mul_a = 31'(u_s[0]); mul_b = 31'(w_s[2]); end
          3'd4: begin mul_a = 31'(u_s[0]); mul_b = 31'(w_s[1]); end
          3'd5: begin mul_a = 31'(u_s[1]); mul_b = 31'(w_s[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_N_SQ: begin
        if (k_q < 3'd3) begin
          mul_a = $signed({1'b0, mag_q[kk][29:0]});
          mul_b = $signed({1'b0, mag_q[kk][29:0]});
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sum of squares; the product of the previous cycle is added.
  assign acc_nx = (k_q == 3'd0) ? 62'd0 : acc_q + $unsigned(prod_q);

  // One step of the bit-pair square root.
  assign sq_cur   = {srem_q, rad_q[61:60]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = (sq_cur >= sq_trial);
  assign sq_diff  = sq_cur - sq_trial;

  // One step of the restoring divider.
  assign dv_cur  = {drem_q, num_q[44]};
  assign dv_ge   = (dv_cur >= {1'b0, len_q});
  assign dv_diff = dv_cur - {1'b0, len_q};
  assign quo_nx  = {quo_q[43:0], dv_ge};

  // Final scaling of a midpoint component, with saturation.
  always_comb begin
    if (!sum_q[kk][16]) begin
      mid_res = (quo_nx > 45'd32767) ? 16'h7FFF : quo_nx[15:0];
    end else begin
      mid_res = (quo_nx >= 45'd32768) ? 16'h8000 : 16'(16'd0 - quo_nx[15:0]);
    end
  end
  assign nrm_res = crs_q[kk][35] ? 16'(16'd0 - quo_nx[15:0]) : quo_nx[15:0];

  // Sequencer and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      j_q         <= 2'd0;
      k_q         <= 3'd0;
      cnt_q       <= 6'd0;
      nmode_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_last_q  <= emit_last;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (tri_valid_i) begin
            state_q <= ST_M_LD;
            j_q     <= 2'd0;
            k_q     <= 3'd0;
          end
        end
        ST_M_LD: begin
          if (k_q == 3'd0) begin
            k_q <= 3'd1;
          end else begin
            k_q     <= 3'd0;
            state_q <= ST_M_SQ;
          end
        end
        ST_M_SQ: begin
          if (k_q == 3'd3) begin
            k_q <= 3'd0;
            if (acc_nx == 62'd0) begin
              state_q <= (j_q == 2'd2) ? ST_N_LD : ST_M_LD;
              j_q     <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
            end else begin
              state_q <= ST_SQRT;
              cnt_q   <= 6'd0;
              nmode_q <= 1'b0;
            end
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        ST_SQRT: begin
          cnt_q <= cnt_q + 6'd1;
          if (sqrt_done) begin
            k_q     <= 3'd0;
            state_q <= nmode_q ? ST_N_DLD : ST_M_MUL;
          end
        end
        ST_M_MUL: state_q <= ST_M_DLD;
        ST_M_DLD: begin
          state_q <= ST_DIV;
          cnt_q   <= 6'd0;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (div_done) begin
            if (k_q != 3'd2) begin
              k_q     <= k_q + 3'd1;
              state_q <= nmode_q ? ST_N_DLD : ST_M_MUL;
            end else if (!nmode_q) begin
              k_q     <= 3'd0;
              state_q <= (j_q == 2'd2) ? ST_N_LD : ST_M_LD;
              j_q     <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
            end else begin
              k_q     <= 3'd0;
              state_q <= (j_q == 2'd3) ? ST_EMIT : ST_N_LD;
              j_q     <= j_q + 2'd1;
            end
          end
        end
        ST_N_LD: begin
          if (k_q == 3'd2) begin
            k_q     <= 3'd0;
            state_q <= ST_N_CR;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        ST_N_CR: begin
          if (k_q == 3'd6) begin
            k_q     <= 3'd0;
            state_q <= ST_N_MAG;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        ST_N_MAG: state_q <= ST_N_NORM;
        ST_N_NORM: begin
          if (or_m == 36'd0) begin
            state_q <= (j_q == 2'd3) ? ST_EMIT : ST_N_LD;
            j_q     <= j_q + 2'd1;
            k_q     <= 3'd0;
          end else if ((or_m[35:30] == 6'd0) && or_m[29]) begin
            state_q <= ST_N_SQ;
            k_q     <= 3'd0;
          end
        end
        ST_N_SQ: begin
          if (k_q == 3'd3) begin
            k_q     <= 3'd0;
            state_q <= ST_SQRT;
            cnt_q   <= 6'd0;
            nmode_q <= 1'b1;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        ST_N_DLD: begin
          state_q <= ST_DIV;
          cnt_q   <= 6'd0;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (emit_last) begin
              state_q <= ST_IDLE;
              j_q     <= 2'd0;
              k_q     <= 3'd0;
            end else if (k_q == 3'd2) begin
              k_q <= 3'd0;
              j_q <= j_q + 2'd1;
            end else begin
              k_q <= k_q + 3'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      ST_IDLE: begin
        if (tri_valid_i) begin
          pt_q[0] <= {tri_i.a.z, tri_i.a.y, tri_i.a.x};
          pt_q[1] <= {tri_i.b.z, tri_i.b.y, tri_i.b.x};
          pt_q[2] <= {tri_i.c.z, tri_i.c.y, tri_i.c.x};
          tx_q[0] <= {tri_i.a.v, tri_i.a.u};
          tx_q[1] <= {tri_i.b.v, tri_i.b.u};
          tx_q[2] <= {tri_i.c.v, tri_i.c.u};
        end
      end
      ST_M_LD: begin
        for (int i = 0; i < 3; i++) begin
          if (k_q == 3'd0) begin
            sum_q[i] <= $signed({rd_pt[i][15], rd_pt[i]});
          end else begin
            sum_q[i] <= sum_q[i] + $signed({rd_pt[i][15], rd_pt[i]});
          end
        end
      end
      ST_M_SQ: begin
        acc_q  <= acc_nx;
        rad_q  <= {acc_nx[45:0], 16'd0};
        srem_q <= '0;
        root_q <= '0;
        if ((k_q == 3'd3) && (acc_nx == 62'd0)) begin
          pt_q[3'(j_q) + PT_D] <= '0;
        end
      end
      ST_SQRT: begin
        rad_q  <= {rad_q[59:0], 2'b00};
        srem_q <= sq_ge ? sq_diff[32:0] : sq_cur[32:0];
        root_q <= {root_q[29:0], sq_ge};
        if (sqrt_done) begin
          len_q <= {root_q[29:0], sq_ge};
        end
      end
      ST_M_DLD: begin
        num_q  <= {prod_q[36:0], 8'd0} + 45'(len_q[30:1]);
        drem_q <= '0;
        quo_q  <= '0;
      end
      ST_DIV: begin
        num_q  <= {num_q[43:0], 1'b0};
        drem_q <= dv_ge ? dv_diff[30:0] : dv_cur[30:0];
        quo_q  <= quo_nx;
        if (div_done) begin
          if (!nmode_q) begin
            pt_q[3'(j_q) + PT_D][kk] <= mid_res;
          end else begin
            nrm_q[j_q][kk] <= nrm_res;
          end
        end
      end
      ST_N_LD: vp_q[kk] <= rd_pt;
      ST_N_CR: begin
        if (k_q == 3'd0) begin
          for (int i = 0; i < 3; i++) begin
            crs_q[i] <= '0;
          end
        end else if (km1[0]) begin
          crs_q[km1[2:1]] <= crs_q[km1[2:1]] - $signed(prod_q[35:0]);
        end else begin
          crs_q[km1[2:1]] <= crs_q[km1[2:1]] + $signed(prod_q[35:0]);
        end
      end
      ST_N_MAG: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= crs_q[i][35] ? 36'(-crs_q[i]) : 36'(crs_q[i]);
        end
      end
      ST_N_NORM: begin
        if (or_m == 36'd0) begin
          nrm_q[j_q] <= '0;
        end else if (or_m[35:30] != 6'd0) begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= {1'b0, mag_q[i][35:1]};
          end
        end else if (!or_m[29]) begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= {mag_q[i][34:0], 1'b0};
          end
        end
      end
      ST_N_SQ: begin
        acc_q  <= acc_nx;
        rad_q  <= acc_nx;
        srem_q <= '0;
        root_q <= '0;
      end
      ST_N_DLD: begin
        num_q  <= {1'b0, mag_q[kk][29:0], 14'd0} + 45'(len_q[30:1]);
        drem_q <= '0;
        quo_q  <= '0;
      end
      ST_EMIT: begin
        if (out_load) begin
          opos_q <= rd_pt;
          onrm_q <= nrm_q[j_q];
          otex_q <= rd_tex;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {otex_q[1], otex_q[0], onrm_q[2], onrm_q[1], onrm_q[0],
                        opos_q[2], opos_q[1], opos_q[0]};

  // The divider never runs with a zero divisor.
  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (len_q != 31'd0))
    else $error("divider started with zero length");

  // A non-zero midpoint sum has a length of at least one unit.
  a_mid_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_M_MUL) |-> (len_q >= 31'd256))
    else $error("midpoint length below one unit");

  // Squares of the normal are taken only once the magnitudes are normalised.
  a_norm_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_N_SQ) |-> (or_m[29] && (or_m[35:30] == 6'd0)))
    else $error("cross product not normalised");

endmodule

`default_nettype wire
